FILE: hdl/lrupbm_pkg.sv
// ============================================================================
// lrupbm_pkg
// Shared types and constants for the LRU page buffer manager.
// ============================================================================
package lrupbm_pkg;

  localparam int FRAMES   = 16;
  localparam int PIN_BITS = 8;
  localparam int FIDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCNT_W   = $clog2(FRAMES + 1);
  localparam int PAGE_W   = 32;
  localparam int CFG_W    = 5;

  // request codes
  localparam logic [2:0] REQ_FETCH     = 3'd0;
  localparam logic [2:0] REQ_NEW_PAGE  = 3'd1;
  localparam logic [2:0] REQ_UNPIN     = 3'd2;
  localparam logic [2:0] REQ_FLUSH     = 3'd3;
  localparam logic [2:0] REQ_FLUSH_ALL = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NOT_RESIDENT = 2'd1;
  localparam logic [1:0] ST_NO_VICTIM    = 2'd2;
  localparam logic [1:0] ST_NOT_PINNED   = 2'd3;

  // one frame table entry
  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic [PIN_BITS-1:0] pins;
    logic                dirty;
    logic [FIDX_W-1:0]   rank;
  } frame_rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_TOUCH,
    S_OUT,
    S_FA_RD,
    S_FA_CHK,
    S_FA_OUT
  } state_t;

endpackage

FILE: hdl/lru_page_buffer_manager.sv
// ============================================================================
// lru_page_buffer_manager
// Frame table with pin counts, dirty marks and LRU replacement.
// ============================================================================
// One request is handled at a time. Every request first scans the frame
// table memory, one entry per cycle, then decides. A fetch hit, or a fetch
// miss or new page that finds a victim, adds a second sweep of the table to
// update the recency ranks; the result is then held until it is taken.
// Flush-all walks the table after the scan, reading and checking each frame
// up to the last dirty frame and offering one result for each dirty frame.
// Free marks are held in flip-flops, so no clearing pass follows reset.
module lru_page_buffer_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] page_number, [32] mark_dirty, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [3:0] frame_index, [35:4] result_page,
                                  // [36] writeback_needed, [68:37] writeback_page,
                                  // [69] fill_needed, [74:70] resident_count
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast,  // is_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // frames_in_use
);

  localparam int FIDX_W = lrupbm_pkg::FIDX_W;
  localparam int FCNT_W = lrupbm_pkg::FCNT_W;
  localparam int PIN_W  = lrupbm_pkg::PIN_BITS;
  localparam logic [FCNT_W-1:0] FRAMES_C = FCNT_W'(lrupbm_pkg::FRAMES);
  localparam logic [FIDX_W-1:0] LAST_IDX = FIDX_W'(lrupbm_pkg::FRAMES - 1);

  // frame table memory
  lrupbm_pkg::frame_rec_t frame_mem [lrupbm_pkg::FRAMES];
  lrupbm_pkg::frame_rec_t rdata_r;
  logic                   rd_en;
  logic [FIDX_W-1:0]      rd_addr;
  logic                   mem_we;
  logic [FIDX_W-1:0]      mem_wa;
  lrupbm_pkg::frame_rec_t mem_wd;

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= frame_mem[rd_addr];
    if (mem_we) frame_mem[mem_wa] <= mem_wd;
  end

  // control state
  lrupbm_pkg::state_t state_r, state_nxt;
  logic [lrupbm_pkg::FRAMES-1:0] free_r, free_nxt;
  logic [FCNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic [31:0]       npg_r, npg_nxt;
  logic [4:0]        cfg_r;
  logic [FCNT_W-1:0] idx_r, idx_nxt;
  logic              rv_r, rv_nxt;
  logic [FIDX_W-1:0] ridx_r, ridx_nxt;

  // latched request
  logic [2:0]  req_r, req_nxt;
  logic [31:0] page_r, page_nxt;
  logic        mark_r, mark_nxt;

  // scan results
  logic              hit_r, hit_nxt;
  logic [FIDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [PIN_W-1:0]  hit_pins_r, hit_pins_nxt;
  logic              hit_dirty_r, hit_dirty_nxt;
  logic [FIDX_W-1:0] hit_rank_r, hit_rank_nxt;
  logic              fre_r, fre_nxt;
  logic [FIDX_W-1:0] fre_idx_r, fre_idx_nxt;
  logic              lru_r, lru_nxt;
  logic [FIDX_W-1:0] lru_idx_r, lru_idx_nxt;
  logic [FIDX_W-1:0] lru_rank_r, lru_rank_nxt;
  logic              lru_dirty_r, lru_dirty_nxt;
  logic [31:0]       lru_page_r, lru_page_nxt;
  logic [FCNT_W-1:0] dcnt_r, dcnt_nxt;

  // recency sweep
  logic [FIDX_W-1:0]      tgt_r, tgt_nxt;
  logic [FCNT_W-1:0]      thr_r, thr_nxt;
  lrupbm_pkg::frame_rec_t trec_r, trec_nxt;

  // result register
  logic [1:0]        o_st_r, o_st_nxt;
  logic [FIDX_W-1:0] o_fr_r, o_fr_nxt;
  logic [31:0]       o_pg_r, o_pg_nxt;
  logic              o_wb_r, o_wb_nxt;
  logic [31:0]       o_wbp_r, o_wbp_nxt;
  logic              o_fill_r, o_fill_nxt;
  logic              o_last_r, o_last_nxt;
  logic [FCNT_W-1:0] o_res_r, o_res_nxt;

  // effective allocation limit
  logic [FCNT_W-1:0] lim;
  always_comb begin
    if (cfg_r == 5'd0) lim = FCNT_W'(1);
    else if ({1'b0, cfg_r} > 6'(lrupbm_pkg::FRAMES)) lim = FRAMES_C;
    else lim = FCNT_W'(cfg_r);
  end

  // masked read data: a free frame reads as all zeros
  lrupbm_pkg::frame_rec_t rrec;
  logic                   rres;
  assign rres = !free_r[ridx_r];
  assign rrec = rres ? rdata_r : '0;

  logic in_acc;
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == lrupbm_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // next state and datapath
  always_comb begin
    logic [31:0] npg_inc;
    logic        vic_ok;
    logic [FIDX_W-1:0] vic;
    lrupbm_pkg::frame_rec_t wrec;
    state_nxt = state_r;
    free_nxt = free_r; res_cnt_nxt = res_cnt_r; npg_nxt = npg_r;
    idx_nxt = idx_r; rv_nxt = 1'b0; ridx_nxt = ridx_r;
    req_nxt = req_r; page_nxt = page_r; mark_nxt = mark_r;
    hit_nxt = hit_r; hit_idx_nxt = hit_idx_r; hit_pins_nxt = hit_pins_r;
    hit_dirty_nxt = hit_dirty_r; hit_rank_nxt = hit_rank_r;
    fre_nxt = fre_r; fre_idx_nxt = fre_idx_r;
    lru_nxt = lru_r; lru_idx_nxt = lru_idx_r; lru_rank_nxt = lru_rank_r;
    lru_dirty_nxt = lru_dirty_r; lru_page_nxt = lru_page_r; dcnt_nxt = dcnt_r;
    tgt_nxt = tgt_r; thr_nxt = thr_r; trec_nxt = trec_r;
    o_st_nxt = o_st_r; o_fr_nxt = o_fr_r; o_pg_nxt = o_pg_r; o_wb_nxt = o_wb_r;
    o_wbp_nxt = o_wbp_r; o_fill_nxt = o_fill_r; o_last_nxt = o_last_r;
    o_res_nxt = o_res_r;
    rd_en = 1'b0; rd_addr = idx_r[FIDX_W-1:0];
    mem_we = 1'b0; mem_wa = ridx_r; mem_wd = rrec;
    npg_inc = npg_r + 32'd1;
    vic_ok = fre_r || lru_r;
    vic = fre_r ? fre_idx_r : lru_idx_r;
    wrec = rrec;

    case (state_r)
      lrupbm_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt  = in_tuser;
          page_nxt = in_tdata[31:0];
          mark_nxt = in_tdata[32];
          hit_nxt = 1'b0; fre_nxt = 1'b0; lru_nxt = 1'b0; dcnt_nxt = '0;
          idx_nxt = '0;
          state_nxt = lrupbm_pkg::S_SCAN;
        end
      end

      // pipelined scan: read one entry a cycle, fold the previous one in
      lrupbm_pkg::S_SCAN: begin
        if (idx_r < FRAMES_C) begin
          rd_en = 1'b1;
          idx_nxt = idx_r + FCNT_W'(1);
          rv_nxt = 1'b1;
          ridx_nxt = idx_r[FIDX_W-1:0];
        end
        if (rv_r) begin
          if (rres && rrec.page == page_r && page_r != 32'd0 && !hit_r) begin
            hit_nxt = 1'b1; hit_idx_nxt = ridx_r; hit_pins_nxt = rrec.pins;
            hit_dirty_nxt = rrec.dirty; hit_rank_nxt = rrec.rank;
          end
          if ({1'b0, ridx_r} < lim) begin
            if (!rres && !fre_r) begin
              fre_nxt = 1'b1; fre_idx_nxt = ridx_r;
            end
            if (rrec.pins == '0 && (!lru_r || rrec.rank > lru_rank_r)) begin
              lru_nxt = 1'b1; lru_idx_nxt = ridx_r; lru_rank_nxt = rrec.rank;
              lru_dirty_nxt = rrec.dirty; lru_page_nxt = rrec.page;
            end
          end
          if (rres && rrec.dirty) dcnt_nxt = dcnt_r + FCNT_W'(1);
          if (ridx_r == LAST_IDX) state_nxt = lrupbm_pkg::S_DECIDE;
        end
      end

      lrupbm_pkg::S_DECIDE: begin
        o_st_nxt = lrupbm_pkg::ST_OK; o_fr_nxt = '0; o_pg_nxt = page_r;
        o_wb_nxt = 1'b0; o_wbp_nxt = '0; o_fill_nxt = 1'b0; o_last_nxt = 1'b1;
        o_res_nxt = res_cnt_r;
        idx_nxt = '0;
        state_nxt = lrupbm_pkg::S_OUT;
        case (req_r)
          lrupbm_pkg::REQ_FETCH, lrupbm_pkg::REQ_NEW_PAGE: begin
            if (req_r == lrupbm_pkg::REQ_NEW_PAGE) begin
              o_pg_nxt = npg_r;
              npg_nxt  = (npg_inc == 32'd0) ? 32'd1 : npg_inc;
            end
            if (req_r == lrupbm_pkg::REQ_FETCH && hit_r) begin
              // hit: pin and make most recent
              o_fr_nxt = hit_idx_r;
              tgt_nxt = hit_idx_r; thr_nxt = FCNT_W'(hit_rank_r);
              trec_nxt.page = page_r;
              trec_nxt.pins = (hit_pins_r == '1) ? hit_pins_r : hit_pins_r + PIN_W'(1);
              trec_nxt.dirty = hit_dirty_r;
              trec_nxt.rank = '0;
              state_nxt = lrupbm_pkg::S_TOUCH;
            end else if (req_r == lrupbm_pkg::REQ_FETCH && page_r == 32'd0) begin
              o_st_nxt = lrupbm_pkg::ST_NOT_RESIDENT;
            end else if (!vic_ok) begin
              o_st_nxt = lrupbm_pkg::ST_NO_VICTIM;
            end else begin
              // place into the victim frame
              o_fr_nxt = vic;
              o_fill_nxt = (req_r == lrupbm_pkg::REQ_FETCH);
              tgt_nxt = vic;
              trec_nxt.page = (req_r == lrupbm_pkg::REQ_FETCH) ? page_r : npg_r;
              trec_nxt.pins = PIN_W'(1);
              trec_nxt.dirty = 1'b0;
              trec_nxt.rank = '0;
              if (fre_r) begin
                thr_nxt = res_cnt_r;
                free_nxt[vic] = 1'b0;
                res_cnt_nxt = res_cnt_r + FCNT_W'(1);
                o_res_nxt = res_cnt_r + FCNT_W'(1);
              end else begin
                thr_nxt = FCNT_W'(lru_rank_r);
                o_wb_nxt = lru_dirty_r;
                o_wbp_nxt = lru_dirty_r ? lru_page_r : 32'd0;
              end
              state_nxt = lrupbm_pkg::S_TOUCH;
            end
          end
          lrupbm_pkg::REQ_UNPIN: begin
            if (!hit_r) begin
              o_st_nxt = lrupbm_pkg::ST_NOT_RESIDENT;
            end else if (hit_pins_r == '0) begin
              o_st_nxt = lrupbm_pkg::ST_NOT_PINNED;
              o_fr_nxt = hit_idx_r;
            end else begin
              o_fr_nxt = hit_idx_r;
              wrec.page = page_r;
              wrec.pins = hit_pins_r - PIN_W'(1);
              wrec.dirty = hit_dirty_r | mark_r;
              wrec.rank = hit_rank_r;
              mem_we = 1'b1; mem_wa = hit_idx_r; mem_wd = wrec;
            end
          end
          lrupbm_pkg::REQ_FLUSH: begin
            if (!hit_r) begin
              o_st_nxt = lrupbm_pkg::ST_NOT_RESIDENT;
            end else begin
              o_fr_nxt = hit_idx_r;
              o_wb_nxt = hit_dirty_r;
              o_wbp_nxt = hit_dirty_r ? page_r : 32'd0;
              wrec.page = page_r;
              wrec.pins = hit_pins_r;
              wrec.dirty = 1'b0;
              wrec.rank = hit_rank_r;
              mem_we = 1'b1; mem_wa = hit_idx_r; mem_wd = wrec;
            end
          end
          lrupbm_pkg::REQ_FLUSH_ALL: begin
            if (dcnt_r != '0) begin
              state_nxt = lrupbm_pkg::S_FA_RD;
            end else begin
              o_pg_nxt = 32'd0;
            end
          end
          default: begin
            state_nxt = lrupbm_pkg::S_IDLE;
          end
        endcase
      end

      // recency sweep: age frames whose rank value is below the old rank of the target
      lrupbm_pkg::S_TOUCH: begin
        if (idx_r < FRAMES_C) begin
          rd_en = 1'b1;
          idx_nxt = idx_r + FCNT_W'(1);
          rv_nxt = 1'b1;
          ridx_nxt = idx_r[FIDX_W-1:0];
        end
        if (rv_r) begin
          if (ridx_r == tgt_r) begin
            mem_we = 1'b1; mem_wd = trec_r;
          end else if (rres) begin
            if (FCNT_W'(rrec.rank) < thr_r) wrec.rank = rrec.rank + FIDX_W'(1);
            mem_we = 1'b1; mem_wd = wrec;
          end
          if (ridx_r == LAST_IDX) state_nxt = lrupbm_pkg::S_OUT;
        end
      end

      lrupbm_pkg::S_OUT: begin
        if (out_tready) state_nxt = lrupbm_pkg::S_IDLE;
      end

      // flush-all walk
      lrupbm_pkg::S_FA_RD: begin
        rd_en = 1'b1;
        ridx_nxt = idx_r[FIDX_W-1:0];
        state_nxt = lrupbm_pkg::S_FA_CHK;
      end

      lrupbm_pkg::S_FA_CHK: begin
        if (rres && rrec.dirty) begin
          wrec.dirty = 1'b0;
          mem_we = 1'b1; mem_wd = wrec;
          o_st_nxt = lrupbm_pkg::ST_OK; o_fr_nxt = ridx_r; o_pg_nxt = rrec.page;
          o_wb_nxt = 1'b1; o_wbp_nxt = rrec.page; o_fill_nxt = 1'b0;
          o_last_nxt = (dcnt_r == FCNT_W'(1)); o_res_nxt = res_cnt_r;
          state_nxt = lrupbm_pkg::S_FA_OUT;
        end else begin
          idx_nxt = idx_r + FCNT_W'(1);
          state_nxt = lrupbm_pkg::S_FA_RD;
        end
      end

      lrupbm_pkg::S_FA_OUT: begin
        if (out_tready) begin
          dcnt_nxt = dcnt_r - FCNT_W'(1);
          idx_nxt = idx_r + FCNT_W'(1);
          state_nxt = (dcnt_r == FCNT_W'(1)) ? lrupbm_pkg::S_IDLE : lrupbm_pkg::S_FA_RD;
        end
      end

      default: begin
        state_nxt = lrupbm_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lrupbm_pkg::S_IDLE;
      free_r    <= '1;
      res_cnt_r <= '0;
      npg_r     <= 32'd1;
      cfg_r     <= 5'd16;
      rv_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      free_r    <= free_nxt;
      res_cnt_r <= res_cnt_nxt;
      npg_r     <= npg_nxt;
      rv_r      <= rv_nxt;
      if (cfg_valid && cfg_ready) cfg_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; ridx_r <= ridx_nxt;
    req_r <= req_nxt; page_r <= page_nxt; mark_r <= mark_nxt;
    hit_r <= hit_nxt; hit_idx_r <= hit_idx_nxt; hit_pins_r <= hit_pins_nxt;
    hit_dirty_r <= hit_dirty_nxt; hit_rank_r <= hit_rank_nxt;
    fre_r <= fre_nxt; fre_idx_r <= fre_idx_nxt;
    lru_r <= lru_nxt; lru_idx_r <= lru_idx_nxt; lru_rank_r <= lru_rank_nxt;
    lru_dirty_r <= lru_dirty_nxt; lru_page_r <= lru_page_nxt; dcnt_r <= dcnt_nxt;
    tgt_r <= tgt_nxt; thr_r <= thr_nxt; trec_r <= trec_nxt;
    o_st_r <= o_st_nxt; o_fr_r <= o_fr_nxt; o_pg_r <= o_pg_nxt; o_wb_r <= o_wb_nxt;
    o_wbp_r <= o_wbp_nxt; o_fill_r <= o_fill_nxt; o_last_r <= o_last_nxt;
    o_res_r <= o_res_nxt;
  end

  // result port
  assign out_tvalid = (state_r == lrupbm_pkg::S_OUT) || (state_r == lrupbm_pkg::S_FA_OUT);
  assign out_tuser  = o_st_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {5'd0, 5'(o_res_r), o_fill_r, o_wbp_r, o_wb_r, o_pg_r, 4'(o_fr_r)};

endmodule

FILE: hdl/lrupbm_checker.sv
// ============================================================================
// lrupbm_checker
// Port-level checks for the LRU page buffer manager, bound to the top level.
// ============================================================================
module lrupbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before it was taken");

  // one request at a time: no new item while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input accepted while a result is pending");

  // no victim reports frame zero
  a_no_victim_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lrupbm_pkg::ST_NO_VICTIM |-> out_tdata[3:0] == 4'd0)
    else $error("no-victim result names a frame");

  // writeback page only when a writeback is asked for
  a_wb_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[36] |-> out_tdata[68:37] == 32'd0)
    else $error("writeback page set without writeback");

  // resident count never exceeds the pool
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[74:70] <= 5'(lrupbm_pkg::FRAMES))
    else $error("resident count out of range");

endmodule

bind lru_page_buffer_manager lrupbm_checker u_lrupbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// LRU page buffer manager testbench
// Drives fetch, new page, unpin, flush and flush-all requests into the frame
// table, predicts every result item from a behavioural model of the pool and
// compares each one field by field. Covers pool size settings 0, 3, 16 and 31.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_ROWS       = 19;
  localparam int NFR          = lrupbm_pkg::FRAMES;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame;
    logic [31:0] page;
    logic        wb;
    logic [31:0] wb_page;
    logic        fill;
    logic        last;
    logic [4:0]  resident;
  } result_t;

  typedef struct {
    logic [2:0]  req;
    logic [31:0] page;
    logic        dirty;
    logic        has_exp;  // typed-in expectation present
    result_t     exp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  lru_page_buffer_manager uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pool model
  logic [31:0] pool_page [NFR];
  logic        pool_free [NFR];
  logic [7:0]  pool_pins [NFR];
  logic        pool_dirty[NFR];
  logic [3:0]  pool_rank [NFR];
  logic [31:0] next_page;
  logic [4:0]  pool_limit;

  result_t expected_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 0;       // no idling in the last part
  bit  hold_rx = 0;    // long receiver hold-off

  // append one expected item at the tail
  function automatic void queue_result(result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic logic [4:0] resident_now();
    logic [4:0] n;
    n = 0;
    for (int i = 0; i < NFR; i++) if (!pool_free[i]) n++;
    return n;
  endfunction

  function automatic int lookup(logic [31:0] pg);
    if (pg == 0) return -1;
    for (int i = 0; i < NFR; i++) if (!pool_free[i] && pool_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic void make_recent(int f, int r);
    for (int i = 0; i < NFR; i++)
      if (i != f && !pool_free[i] && pool_rank[i] < r) pool_rank[i]++;
    pool_rank[f] = 0;
  endfunction

  function automatic int pick_victim();
    int lim;
    int best;
    lim = pool_limit;
    best = -1;
    if (lim == 0) lim = 1;
    if (lim > NFR) lim = NFR;
    for (int i = 0; i < lim; i++) if (pool_free[i]) return i;
    for (int i = 0; i < lim; i++)
      if (pool_pins[i] == 0 && (best < 0 || pool_rank[i] > pool_rank[best])) best = i;
    return best;
  endfunction

  function automatic result_t mk(logic [1:0] st, int f, logic [31:0] pg, logic wb,
                                 logic [31:0] wbp, logic fill, logic last);
    result_t r;
    r.status = st; r.frame = f[3:0]; r.page = pg; r.wb = wb; r.wb_page = wbp;
    r.fill = fill; r.last = last; r.resident = resident_now();
    return r;
  endfunction

  // claim frame f for page pg, returns the result with writeback filled in
  function automatic result_t occupy(int f, logic [31:0] pg, logic fill);
    logic wb;
    logic [31:0] wbp;
    int r;
    wb = 0; wbp = 0;
    if (pool_free[f]) r = resident_now();
    else begin
      r = pool_rank[f];
      if (pool_dirty[f]) begin
        wb = 1; wbp = pool_page[f];
      end
    end
    make_recent(f, r);
    pool_page[f] = pg; pool_free[f] = 0; pool_pins[f] = 1; pool_dirty[f] = 0;
    return mk(lrupbm_pkg::ST_OK, f, pg, wb, wbp, fill, 1'b1);
  endfunction

  // work out the result items of one request and queue them
  function automatic int predict_request(logic [2:0] req, logic [31:0] pg, logic dm);
    int f;
    int k;
    result_t r;
    k = 0;
    case (req)
      lrupbm_pkg::REQ_FETCH: begin
        f = lookup(pg);
        if (f >= 0) begin
          if (pool_pins[f] != 8'hFF) pool_pins[f]++;
          make_recent(f, pool_rank[f]);
          r = mk(lrupbm_pkg::ST_OK, f, pg, 0, 0, 0, 1);
        end else if (pg == 0) r = mk(lrupbm_pkg::ST_NOT_RESIDENT, 0, pg, 0, 0, 0, 1);
        else begin
          f = pick_victim();
          if (f < 0) r = mk(lrupbm_pkg::ST_NO_VICTIM, 0, pg, 0, 0, 0, 1);
          else r = occupy(f, pg, 1'b1);
        end
        queue_result(r); k = 1;
      end
      lrupbm_pkg::REQ_NEW_PAGE: begin
        pg = next_page;
        next_page++;
        if (next_page == 0) next_page = 1;
        f = pick_victim();
        if (f < 0) r = mk(lrupbm_pkg::ST_NO_VICTIM, 0, pg, 0, 0, 0, 1);
        else r = occupy(f, pg, 1'b0);
        queue_result(r); k = 1;
      end
      lrupbm_pkg::REQ_UNPIN: begin
        f = lookup(pg);
        if (f < 0) r = mk(lrupbm_pkg::ST_NOT_RESIDENT, 0, pg, 0, 0, 0, 1);
        else if (pool_pins[f] == 0) r = mk(lrupbm_pkg::ST_NOT_PINNED, f, pg, 0, 0, 0, 1);
        else begin
          pool_pins[f]--;
          if (dm) pool_dirty[f] = 1;
          r = mk(lrupbm_pkg::ST_OK, f, pg, 0, 0, 0, 1);
        end
        queue_result(r); k = 1;
      end
      lrupbm_pkg::REQ_FLUSH: begin
        f = lookup(pg);
        if (f < 0) r = mk(lrupbm_pkg::ST_NOT_RESIDENT, 0, pg, 0, 0, 0, 1);
        else begin
          r = mk(lrupbm_pkg::ST_OK, f, pg, pool_dirty[f], pool_dirty[f] ? pg : 32'd0, 0, 1);
          pool_dirty[f] = 0;
        end
        queue_result(r); k = 1;
      end
      lrupbm_pkg::REQ_FLUSH_ALL: begin
        for (int i = 0; i < NFR; i++)
          if (!pool_free[i] && pool_dirty[i]) begin
            pool_dirty[i] = 0;
            queue_result(mk(lrupbm_pkg::ST_OK, i, pool_page[i], 1, pool_page[i], 0, 0));
            k++;
          end
        if (k == 0) begin
          queue_result(mk(lrupbm_pkg::ST_OK, 0, 0, 0, 0, 0, 1)); k = 1;
        end else expected_q[$].last = 1'b1;
      end
      default: k = 0;
    endcase
    return k;
  endfunction

  // per-cycle bookkeeping and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser; got.frame = out_tdata[3:0]; got.page = out_tdata[35:4];
      got.wb = out_tdata[36]; got.wb_page = out_tdata[68:37]; got.fill = out_tdata[69];
      got.last = out_tlast; got.resident = out_tdata[74:70];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp = expected_q[0];
        expected_q.delete(0);
        if (got !== exp) begin
          $display("%0t: mismatch expected st=%0d fr=%0d pg=%h wb=%0d wbp=%h %s",
                   $time, exp.status, exp.frame, exp.page, exp.wb, exp.wb_page,
                   $sformatf("fill=%0d last=%0d res=%0d", exp.fill, exp.last,
                             exp.resident));
          $display("%0t:          actual   st=%0d fr=%0d pg=%h wb=%0d wbp=%h %s",
                   $time, got.status, got.frame, got.page, got.wb, got.wb_page,
                   $sformatf("fill=%0d last=%0d res=%0d", got.fill, got.last,
                             got.resident));
          errors++;
        end
      end
    end
  end

  // receiver: random stall bursts, long hold-off on request
  always @(posedge clk) begin
    int gap;
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_rx) out_tready <= 1'b0;
    else if (calm) out_tready <= 1'b1;
    else if (gap > 0) begin
      gap--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  task automatic write_limit(logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_limit = v;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // offer one item, optional random gap first; prediction at acceptance
  task automatic send_request(logic [2:0] req, logic [31:0] pg, logic dm);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'd0, dm, pg};
    do @(posedge clk); while (!in_tready);
    void'(predict_request(req, pg, dm));
  endtask

  function automatic logic [31:0] some_page();
    int i;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'd0;
      2, 3: return $urandom_range(1, 40);
      default: begin
        i = $urandom_range(0, NFR - 1);
        return pool_free[i] ? $urandom_range(1, 40) : pool_page[i];
      end
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [2:0] req;
    int pick;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) req = lrupbm_pkg::REQ_FETCH;
      else if (pick < 45) req = lrupbm_pkg::REQ_NEW_PAGE;
      else if (pick < 75) req = lrupbm_pkg::REQ_UNPIN;
      else if (pick < 88) req = lrupbm_pkg::REQ_FLUSH;
      else if (pick < 96) req = lrupbm_pkg::REQ_FLUSH_ALL;
      else req = 3'($urandom_range(5, 7));
      send_request(req, some_page(), 1'($urandom_range(0, 1)));
    end
    in_tvalid <= 1'b0;
  endtask

  row_t rows [N_ROWS];
  result_t saved;

  initial begin
    for (int i = 0; i < NFR; i++) begin
      pool_page[i] = 0; pool_free[i] = 1; pool_pins[i] = 0;
      pool_dirty[i] = 0; pool_rank[i] = 0;
    end
    next_page = 1;
    pool_limit = 16;

    // directed table: typed expectations where they are obvious
    rows[0] = '{lrupbm_pkg::REQ_FETCH, 32'd0, 1'b0, 1'b1,
               '{lrupbm_pkg::ST_NOT_RESIDENT, 4'd0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1, 5'd0}};
    rows[1] = '{lrupbm_pkg::REQ_FLUSH_ALL, 32'd0, 1'b0, 1'b1,
               '{lrupbm_pkg::ST_OK, 4'd0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1, 5'd0}};
    rows[2] = '{lrupbm_pkg::REQ_UNPIN, 32'hFFFFFFFF, 1'b1, 1'b1,
               '{lrupbm_pkg::ST_NOT_RESIDENT, 4'd0, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0, 1'b1,
                 5'd0}};
    rows[3] = '{lrupbm_pkg::REQ_FLUSH, 32'd0, 1'b0, 1'b1,
               '{lrupbm_pkg::ST_NOT_RESIDENT, 4'd0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1, 5'd0}};
    rows[4] = '{lrupbm_pkg::REQ_NEW_PAGE, 32'd0, 1'b0, 1'b1,
               '{lrupbm_pkg::ST_OK, 4'd0, 32'd1, 1'b0, 32'd0, 1'b0, 1'b1, 5'd1}};
    rows[5] = '{lrupbm_pkg::REQ_FETCH, 32'hFFFFFFFF, 1'b0, 1'b1,
               '{lrupbm_pkg::ST_OK, 4'd1, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b1, 1'b1, 5'd2}};
    rows[6]  = '{3'd5, 32'hA5A5A5A5, 1'b1, 1'b0, '0};
    rows[7]  = '{3'd7, 32'h5A5A5A5A, 1'b0, 1'b0, '0};
    rows[8]  = '{lrupbm_pkg::REQ_FETCH, 32'd2, 1'b0, 1'b0, '0};   // duplicate of next new page
    rows[9]  = '{lrupbm_pkg::REQ_NEW_PAGE, 32'd0, 1'b0, 1'b0, '0};
    rows[10] = '{lrupbm_pkg::REQ_FETCH, 32'd1, 1'b0, 1'b0, '0};
    rows[11] = '{lrupbm_pkg::REQ_UNPIN, 32'd1, 1'b1, 1'b0, '0};
    rows[12] = '{lrupbm_pkg::REQ_UNPIN, 32'd1, 1'b0, 1'b0, '0};
    rows[13] = '{lrupbm_pkg::REQ_UNPIN, 32'd1, 1'b0, 1'b0, '0};   // not pinned
    rows[14] = '{lrupbm_pkg::REQ_UNPIN, 32'hFFFFFFFF, 1'b1, 1'b0, '0};
    rows[15] = '{lrupbm_pkg::REQ_FLUSH, 32'd2, 1'b0, 1'b0, '0};   // clean page
    rows[16] = '{lrupbm_pkg::REQ_FLUSH, 32'd1, 1'b0, 1'b0, '0};   // dirty page
    rows[17] = '{lrupbm_pkg::REQ_UNPIN, 32'd2, 1'b1, 1'b0, '0};
    rows[18] = '{lrupbm_pkg::REQ_FLUSH_ALL, 32'd0, 1'b0, 1'b0, '0};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_request(rows[i].req, rows[i].page, rows[i].dirty);
      if (rows[i].has_exp) begin
        saved = expected_q[$];
        if (saved !== rows[i].exp) begin
          $display("%0t: table row %0d expected %h, model gives %h",
                   $time, i, rows[i].exp, saved);
          errors++;
        end
      end
    end
    in_tvalid <= 1'b0;

    // pin saturation: 260 fetches of one page
    for (int j = 0; j < 260; j++) send_request(lrupbm_pkg::REQ_FETCH, 32'd1, 1'b0);
    in_tvalid <= 1'b0;
    wait_drained();

    // smallest pool, no victim while pinned
    write_limit(5'd0);
    random_phase(40);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_rx = 1;
        repeat (400) @(posedge clk);
        hold_rx = 0;
      end
      random_phase(30);
    join
    wait_drained();

    write_limit(5'd3);
    random_phase(40);
    wait_drained();

    write_limit(5'd31);
    random_phase(40);
    wait_drained();

    // counter wrap: burn through new pages is impractical, so exercise large pool
    write_limit(5'd16);
    random_phase(30);
    calm = 1;
    random_phase(20);

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
